[hw/rtl/mep_pkg.sv]
// ----------------------------------------------------------------------------
// mep_pkg: shared types and constants for the Mandelbrot escape pixel unit
// Fixed-point formats, coordinate mapping, saturation and divider cell word.
// ----------------------------------------------------------------------------
package mep_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int FX_W       = FRAC_BITS + 4;
  localparam int PROD_W     = FX_W + 4;
  localparam int ACC_W      = FX_W + 6;
  localparam int COORD_W    = 12;
  localparam int IMG_LOG2   = 12;
  localparam int CNT_W      = 8;
  localparam int DIV_W      = 2 * CNT_W;
  localparam int DIV_STAGES = CNT_W;
  localparam int C_SHIFT    = FRAC_BITS + 2 - IMG_LOG2;

  localparam logic signed [ACC_W-1:0] FX_MAX_ACC = ACC_W'((64'sd1 <<< (FX_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] FX_MIN_ACC = -ACC_W'(64'sd1 <<< (FX_W - 1));
  localparam logic signed [ACC_W-1:0] ESC_BOUND  = ACC_W'(64'sd4 <<< FRAC_BITS);
  localparam logic [FX_W-1:0]         C_OFFSET   = FX_W'(64'd2 << FRAC_BITS);

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_MUL,
    CORE_ADD,
    CORE_DONE
  } core_state_e;

  // Word handed from one divider cell to the next
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dsh;
    logic [CNT_W-1:0] quo;
    logic [CNT_W-1:0] count;
    logic             in_set;
  } div_word_t;

  // Clamp a wide sum to the fixed-point range
  function automatic logic signed [FX_W-1:0] fx_sat(input logic signed [ACC_W-1:0] v);
    logic signed [FX_W-1:0] r;
    if (v > FX_MAX_ACC) begin
      r = FX_MAX_ACC[FX_W-1:0];
    end else if (v < FX_MIN_ACC) begin
      r = FX_MIN_ACC[FX_W-1:0];
    end else begin
      r = v[FX_W-1:0];
    end
    return r;
  endfunction

  // Map a pixel index to 4*(idx/size - 0.5); image size is a power of two
  function automatic logic signed [FX_W-1:0] map_coord(input logic [COORD_W-1:0] idx);
    logic [FX_W-1:0] s;
    s = FX_W'(idx) << C_SHIFT;
    return signed'(s - C_OFFSET);
  endfunction

endpackage

[hw/rtl/mep_iter_core.sv]
// ----------------------------------------------------------------------------
// mep_iter_core: escape-time iteration engine
// Runs z = z*z + c with one registered product step and one update step.
// ----------------------------------------------------------------------------
module mep_iter_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mep_pkg::COORD_W-1:0] row_i,
  input  logic [mep_pkg::COORD_W-1:0] col_i,
  input  logic [mep_pkg::CNT_W-1:0] limit_i,
  output logic                      idle_o,
  output logic                      done_o,
  output logic [mep_pkg::CNT_W-1:0] count_o,
  output logic [mep_pkg::CNT_W-1:0] limit_o
);
  import mep_pkg::*;

  core_state_e state_q, state_d;
  logic signed [FX_W-1:0]   cx_q, cy_q, x_q, y_q, x_d, y_d;
  logic signed [PROD_W-1:0] xx_q, yy_q, xy_q;
  logic signed [2*FX_W-1:0] p_xx, p_yy, p_xy;
  logic signed [ACC_W-1:0]  mag2, x_sum, y_sum;
  logic [CNT_W-1:0]         n_q, n_d, lim_q;
  logic                     escape;

  // Products floored by the arithmetic shift
  assign p_xx = x_q * x_q;
  assign p_yy = y_q * y_q;
  assign p_xy = x_q * y_q;

  assign mag2   = ACC_W'(xx_q) + ACC_W'(yy_q);
  assign escape = mag2 > ESC_BOUND;
  assign x_sum  = ACC_W'(xx_q) - ACC_W'(yy_q) + ACC_W'(cx_q);
  assign y_sum  = (ACC_W'(xy_q) <<< 1) + ACC_W'(cy_q);
  assign x_d    = fx_sat(x_sum);
  assign y_d    = fx_sat(y_sum);
  assign n_d    = n_q + CNT_W'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CORE_IDLE: begin
        if (start_i) begin
          state_d = (limit_i == '0) ? CORE_DONE : CORE_MUL;
        end
      end
      CORE_MUL: state_d = CORE_ADD;
      CORE_ADD: begin
        if (escape || (n_d == lim_q)) begin
          state_d = CORE_DONE;
        end else begin
          state_d = CORE_MUL;
        end
      end
      CORE_DONE: state_d = CORE_IDLE;
      default:   state_d = CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: load point, register products, update z
  always_ff @(posedge clk_i) begin
    if (state_q == CORE_IDLE && start_i) begin
      cx_q  <= map_coord(col_i);
      cy_q  <= map_coord(row_i);
      x_q   <= '0;
      y_q   <= '0;
      n_q   <= '0;
      lim_q <= limit_i;
    end
    if (state_q == CORE_MUL) begin
      xx_q <= PROD_W'(p_xx >>> FRAC_BITS);
      yy_q <= PROD_W'(p_yy >>> FRAC_BITS);
      xy_q <= PROD_W'(p_xy >>> FRAC_BITS);
    end
    if (state_q == CORE_ADD && !escape) begin
      x_q <= x_d;
      y_q <= y_d;
      n_q <= n_d;
    end
  end

  assign idle_o  = (state_q == CORE_IDLE);
  assign done_o  = (state_q == CORE_DONE);
  assign count_o = n_q;
  assign limit_o = lim_q;

endmodule

[hw/rtl/mep_div_cell.sv]
// ----------------------------------------------------------------------------
// mep_div_cell: one restoring division cell
// Produces one quotient bit and hands the word to the next cell.
// ----------------------------------------------------------------------------
module mep_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  mep_pkg::div_word_t  word_i,
  output logic                valid_o,
  output mep_pkg::div_word_t  word_o
);
  import mep_pkg::*;

  logic      valid_q;
  div_word_t word_q, word_d;
  logic      take;

  // Subtract the shifted divisor when it fits
  always_comb begin
    word_d = word_i;
    take   = (word_i.rem >= word_i.dsh);
    if (take) begin
      word_d.rem = word_i.rem - word_i.dsh;
    end
    word_d.dsh = word_i.dsh >> 1;
    word_d.quo = {word_i.quo[CNT_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

[hw/rtl/mep_gray_div.sv]
// ----------------------------------------------------------------------------
// mep_gray_div: chain of division cells for the gray level
// Computes 255*count/limit one quotient bit per cell.
// ----------------------------------------------------------------------------
module mep_gray_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic [mep_pkg::CNT_W-1:0] count_i,
  input  logic [mep_pkg::CNT_W-1:0] limit_i,
  output logic                      busy_o,
  output logic                      valid_o,
  output logic [mep_pkg::CNT_W-1:0] gray_o,
  output logic [mep_pkg::CNT_W-1:0] count_o,
  output logic                      inside_o
);
  import mep_pkg::*;

  logic      v   [DIV_STAGES+1];
  div_word_t w   [DIV_STAGES+1];
  logic [DIV_STAGES-1:0] cell_valid;

  // Seed: dividend 255*n, divisor aligned to the top quotient bit
  always_comb begin
    v[0]        = valid_i;
    w[0].rem    = (DIV_W'(count_i) << CNT_W) - DIV_W'(count_i);
    w[0].dsh    = DIV_W'(limit_i) << (CNT_W - 1);
    w[0].quo    = '0;
    w[0].count  = count_i;
    w[0].in_set = (count_i == limit_i);
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_cell
    mep_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv_i),
      .valid_i (v[k]),
      .word_i  (w[k]),
      .valid_o (v[k+1]),
      .word_o  (w[k+1])
    );
    assign cell_valid[k] = v[k+1];
  end

  assign busy_o   = |cell_valid;
  assign valid_o  = v[DIV_STAGES];
  // A zero count gives zero, which also covers a zero limit
  assign gray_o   = (w[DIV_STAGES].count == '0) ? '0 : w[DIV_STAGES].quo;
  assign count_o  = w[DIV_STAGES].count;
  assign inside_o = w[DIV_STAGES].in_set;

endmodule

[hw/rtl/mandelbrot_escape_pixel_unit.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_unit: escape-time result for one pixel
// Maps (row, column) to c, iterates z = z*z + c, reports count and gray level.
//
//   Channel   Dir  Payload
//   s_axis    in   tdata[11:0] pixel_row, tdata[23:12] pixel_column
//   m_axis    out  tdata[7:0] gray_level, tdata[15:8] iteration_count,
//                  tuser[0] inside_set
//   cfg       in   cfg_wr_data_i[7:0] iteration_limit (reset 100)
//
// The iteration core spends a product and an update step on each iteration
// done and on the step that finds an escape, then a done state; a zero limit
// takes the done state only. The result then passes through the divider
// cell chain into the output register. One pixel is in work at a time:
// input waits until the core is idle and the chain is empty.
// Reset clears control state only; the limit resets to 100.
// A waiting result in the output register stalls the whole divider chain.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [11:0] pixel_row, [23:12] pixel_column
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] gray_level, [15:8] iteration_count
  output logic [0:0]  m_axis_tuser,   // [0] inside_set
  input  logic        cfg_wr_en_i,
  input  logic [7:0]  cfg_wr_data_i
);
  import mep_pkg::*;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(100);

  logic [CNT_W-1:0] limit_q;
  logic             core_idle, core_done, in_xfer;
  logic [CNT_W-1:0] core_count, core_limit;
  logic             div_busy, div_valid, div_inside, out_load, chain_adv;
  logic [CNT_W-1:0] div_gray, div_count;
  logic             out_valid_q, out_inside_q;
  logic [CNT_W-1:0] out_gray_q, out_count_q;

  // Hold the iteration limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_wr_en_i) begin
      limit_q <= cfg_wr_data_i;
    end
  end

  assign s_axis_tready = core_idle && !div_busy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  mep_iter_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .row_i   (s_axis_tdata[11:0]),
    .col_i   (s_axis_tdata[23:12]),
    .limit_i (limit_q),
    .idle_o  (core_idle),
    .done_o  (core_done),
    .count_o (core_count),
    .limit_o (core_limit)
  );

  // Advance the chain unless its result waits on a full output register
  assign out_load  = div_valid && (!out_valid_q || m_axis_tready);
  assign chain_adv = !div_valid || out_load;

  mep_gray_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (chain_adv),
    .valid_i  (core_done),
    .count_i  (core_count),
    .limit_i  (core_limit),
    .busy_o   (div_busy),
    .valid_o  (div_valid),
    .gray_o   (div_gray),
    .count_o  (div_count),
    .inside_o (div_inside)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_gray_q   <= div_gray;
      out_count_q  <= div_count;
      out_inside_q <= div_inside;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_count_q, out_gray_q};
  assign m_axis_tuser  = out_inside_q;

endmodule

[hw/rtl/mep_checker.sv]
// ----------------------------------------------------------------------------
// mep_checker: port-level checks for the escape pixel unit
// Watches the stream ports and the relation of count, gray and inside flag.
// ----------------------------------------------------------------------------
module mep_port_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // One pixel at a time: no transfer right after one
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // Zero iterations give black
  a_zero_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[15:8] == 8'd0 |-> m_axis_tdata[7:0] == 8'd0)
    else $error("gray not zero for zero count");

  // Reaching a nonzero limit gives white
  a_inside_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[15:8] != 8'd0
      |-> m_axis_tdata[7:0] == 8'd255)
    else $error("inside pixel not full gray");

endmodule

bind mandelbrot_escape_pixel_unit mep_port_assert u_mep_port_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/mep_checker.sv]
// ----------------------------------------------------------------------------
// mep_checker: result predictor and scoreboard for the escape pixel unit
// Watches the pixel and result channels, computes the escape-time result of
// each accepted pixel under the current iteration limit, compares in order.
// ----------------------------------------------------------------------------
module mep_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  input  logic        cfg_wr_en_i,
  input  logic [7:0]  cfg_wr_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] gray;
    logic [7:0] count;
    logic       in_set;
  } pixel_result_t;

  localparam int FB = mep_pkg::FRAC_BITS;
  localparam longint FMAX = (64'sd1 <<< (FB + 3)) - 1;
  localparam longint FMIN = -(64'sd1 <<< (FB + 3));

  pixel_result_t result_q[$];
  logic [7:0]    limit_q;

  assign pending_o = result_q.size();

  function automatic longint clamp_fx(longint v);
    if (v > FMAX) return FMAX;
    if (v < FMIN) return FMIN;
    return v;
  endfunction

  // Product truncated toward minus infinity
  function automatic longint mul_fx(longint a, longint b);
    return (a * b) >>> FB;
  endfunction

  function automatic pixel_result_t escape_pixel(logic [11:0] row, logic [11:0] col,
                                                 logic [7:0] lim);
    pixel_result_t r;
    longint cy, cx, x, y, xx, yy, xy;
    int n;
    cy = clamp_fx(((longint'(row) << (FB + 2)) / 4096) - (64'sd2 <<< FB));
    cx = clamp_fx(((longint'(col) << (FB + 2)) / 4096) - (64'sd2 <<< FB));
    x = 0;
    y = 0;
    n = 0;
    while (n < lim) begin
      xx = mul_fx(x, x);
      yy = mul_fx(y, y);
      if (xx + yy > (64'sd4 <<< FB)) break;
      xy = mul_fx(x, y);
      x = clamp_fx(xx - yy + cx);
      y = clamp_fx(2 * xy + cy);
      n++;
    end
    r.gray   = (lim == 0) ? 8'd0 : 8'((255 * n) / lim);
    r.count  = 8'(n);
    r.in_set = (n == lim);
    return r;
  endfunction

  // Predict on each pixel transfer, compare on each result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t e;
    if (!rst_ni) begin
      limit_q      <= 8'd100;
      fail_count_o <= 0;
      result_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.push_back(escape_pixel(s_axis_tdata[11:0], s_axis_tdata[23:12], limit_q));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = result_q.pop_front();
          if (m_axis_tdata[7:0] !== e.gray || m_axis_tdata[15:8] !== e.count ||
              m_axis_tuser[0] !== e.in_set) begin
            if (fail_count_o < 10) begin
              $display("mismatch: exp gray %0d count %0d inside %0d, got %0d %0d %0d",
                       e.gray, e.count, e.in_set, m_axis_tdata[7:0],
                       m_axis_tdata[15:8], m_axis_tuser[0]);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_wr_en_i) limit_q <= cfg_wr_data_i;
    end
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the Mandelbrot escape pixel unit
// Drives directed and random pixels under several iteration limits with
// random gaps and result stalls; a checker module scores every result.
// ----------------------------------------------------------------------------
module testbench;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // [11:0] pixel_row, [23:12] pixel_column
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [7:0] gray_level, [15:8] iteration_count
  logic [0:0]  m_axis_tuser;         // [0] inside_set
  logic        cfg_wr_en_i = 1'b0;
  logic [7:0]  cfg_wr_data_i = '0;
  int          fail_count;
  int          pending;
  logic        out_done = 1'b0;

  always #5 clk_i = ~clk_i;

  mandelbrot_escape_pixel_unit i_dut (.*);

  mep_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_wr_en_i, .cfg_wr_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  // Send one pixel after a random gap; valid stays high for a zero gap
  task automatic send_pixel(logic [11:0] row, logic [11:0] col);
    int gap;
    gap = $urandom_range(0, 14);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {col, row};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and wait for all results to drain
  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Wait for all results to drain, then set a new limit
  task automatic drain_and_set(logic [7:0] lim);
    drain_all();
    repeat (20) @(posedge clk_i);
    cfg_wr_data_i <= lim;
    cfg_wr_en_i   <= 1'b1;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
  endtask

  // Random result stalls: a fresh wait before each result
  initial begin
    int gap;
    @(posedge rst_ni);
    while (!out_done) begin
      gap = $urandom_range(0, 14);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid && !out_done);
    end
  end

  initial begin
    logic [7:0] limits [6];
    logic [11:0] r, c;
    limits = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd100, 8'd37};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: corners, center, near-boundary points, at reset limit
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd2048, 12'd1024);
    send_pixel(12'd2048, 12'd3072);
    send_pixel(12'd2048, 12'd2560);
    send_pixel(12'd1500, 12'd1700);
    send_pixel(12'hAAA, 12'h555);
    foreach (limits[k]) begin
      drain_and_set(limits[k]);
      send_pixel(12'd2048, 12'd2048);
      send_pixel(12'd0, 12'd0);
      repeat (170) begin
        // Mostly points around the set, some anywhere
        if ($urandom_range(0, 3) == 0) begin
          r = 12'($urandom);
          c = 12'($urandom);
        end else begin
          r = 12'($urandom_range(1000, 3096));
          c = 12'($urandom_range(500, 2600));
        end
        send_pixel(r, c);
      end
    end
    drain_all();
    repeat (50) @(posedge clk_i);
    out_done = 1'b1;
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("testbench failed");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mep_pkg.sv
hw/rtl/mep_iter_core.sv
hw/rtl/mep_div_cell.sv
hw/rtl/mep_gray_div.sv
hw/rtl/mandelbrot_escape_pixel_unit.sv
hw/rtl/mep_checker.sv
tb/mep_checker.sv
tb/testbench.sv
